// File: rtl/adjacency_list_bfs_dfs_walker_core_assert.svh
// ----------------------------------------------------------------------------
// Walker assertion macros
// Shorthand for the clocked, reset-gated properties of the walker core.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_LIST_BFS_DFS_WALKER_CORE_ASSERT_SVH
`define ADJACENCY_LIST_BFS_DFS_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk while rst_n is high.
`define ALW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("walker check failed: same-cycle implication");

// Next-cycle implication, sampled on clk while rst_n is high.
`define ALW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("walker check failed: next-cycle implication");

`endif

// File: rtl/alw_pkg.sv
// ----------------------------------------------------------------------------
// Walker package
// Field widths, codes and the result record of the graph walker.
// ----------------------------------------------------------------------------
`default_nettype none

package alw_pkg;

  localparam int NODE_W         = 6;
  localparam int WT_W           = 16;
  localparam int NODE_SLOTS     = 64;
  localparam int MAX_NODES_DEF  = 63;
  localparam int EDGE_SLOTS_DEF = 256;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_START_NODE = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_BFS   = 2'd2,
    MODE_DFS   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_VISIT  = 3'd0,
    ST_STORED = 3'd1,
    ST_FULL   = 3'd2,
    ST_BAD    = 3'd3,
    ST_CLEAR  = 3'd4
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] depth;
    logic [NODE_W-1:0] parent;
    logic [WT_W-1:0]   wt;
  } res_t;

  function automatic res_t mk_res(status_t st, logic [NODE_W-1:0] nd,
                                  logic [NODE_W-1:0] dp, logic [NODE_W-1:0] par,
                                  logic [WT_W-1:0] w);
    res_t r;
    r.status = st;
    r.node   = nd;
    r.depth  = dp;
    r.parent = par;
    r.wt     = w;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/alw_ram.sv
// ----------------------------------------------------------------------------
// Walker RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module alw_ram #(
  parameter int WIDTH = alw_pkg::NODE_W,
  parameter int DEPTH = alw_pkg::NODE_SLOTS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/adjacency_list_bfs_dfs_walker_core.sv
// Clear and rejected items go from idle straight to S_FIN; an added edge
// passes S_ADD_WA, S_ADD_RB and S_ADD_WB first. A walk pops each work entry
// via S_POP, S_NODE and S_LINK, and S_CHK reads its list on the edge RAM port.
// One item is handled at a time; in_tready is high only while idle.
// Reset (synchronous, rst_n low) empties all lists and the edge count and
// loads node_count 63 and start_node 1; no memory clearing pass is needed.
`default_nettype none
`include "adjacency_list_bfs_dfs_walker_core_assert.svh"

// ----------------------------------------------------------------------------
// Adjacency-list walker core
// Stores an undirected weighted graph and runs breadth- or depth-first walks.
// ----------------------------------------------------------------------------
module adjacency_list_bfs_dfs_walker_core #(
  parameter int MAX_NODES  = alw_pkg::MAX_NODES_DEF,
  parameter int EDGE_SLOTS = alw_pkg::EDGE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // node_a [5:0], node_b [11:6], edge_weight [27:12], zero pad [31:28]
  input  wire logic [31:0] in_tdata,
  // mode [1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // visited_node [5:0], depth [11:6], parent_node [17:12],
  // tree_weight [33:18], zero pad [39:34]
  output logic [39:0]      out_tdata,
  // status [2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NW   = alw_pkg::NODE_W;
  localparam int WW   = alw_pkg::WT_W;
  localparam int NS   = alw_pkg::NODE_SLOTS;
  // Edge index width, and link width: a link holds index+1, zero ends a list.
  localparam int EW   = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int LW   = EW + 1;
  localparam int EE_W = LW + NW + WW;
  localparam int WL_W = 2 * NW;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ADD_WA = 9'b000000010,
    S_ADD_RB = 9'b000000100,
    S_ADD_WB = 9'b000001000,
    S_POP    = 9'b000010000,
    S_NODE   = 9'b000100000,
    S_LINK   = 9'b001000000,
    S_CHK    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [NW-1:0] ncnt_r, strt_r;
  logic          cfg_wr;

  // Graph bookkeeping.
  logic [NS-1:0] hv_r, hv_nxt;       // list-head valid bits
  logic [NS-1:0] vis_r, vis_nxt;     // visit marks
  logic [LW-1:0] total_r, total_nxt;
  logic [NW-1:0] hrd_addr_r, hrd_addr_nxt;

  // Item and walk registers.
  logic [NW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic          dfs_r, dfs_nxt;
  logic [NW-1:0] head_r, head_nxt, tail_r, tail_nxt, top_r, top_nxt;
  logic [NW-1:0] x_r, x_nxt, d_r, d_nxt;

  // Pending result (held back until it is known whether it is the last one)
  // and the output register.
  logic               pend_vld_r, pend_vld_nxt;
  alw_pkg::res_t      pend_r, pend_nxt;
  logic               out_vld_r, out_vld_nxt;
  alw_pkg::res_t      out_r, out_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_free;

  // RAM ports.
  logic            h_we, h_re;
  logic [NW-1:0]   h_waddr, h_raddr;
  logic [LW-1:0]   h_wdata, h_rdata, heff, lm1;
  logic            e_we, e_re;
  logic [EW-1:0]   e_waddr, e_raddr;
  logic [EE_W-1:0] e_wdata, e_rdata;
  logic            wl_we, wl_re;
  logic [NW-1:0]   wl_waddr, wl_raddr;
  logic [WL_W-1:0] wl_wdata, wl_rdata;

  // Input fields and derived checks.
  alw_pkg::mode_t in_mode;
  logic [NW-1:0]  in_a, in_b, lim, e_to, d_inc;
  logic [WW-1:0]  in_w, e_wt;
  logic [LW-1:0]  e_nl;
  logic           bad_edge, bad_start, full, can_take;

  assign in_mode = alw_pkg::mode_t'(in_tuser);
  assign in_a    = in_tdata[NW-1:0];
  assign in_b    = in_tdata[2*NW-1:NW];
  assign in_w    = in_tdata[2*NW+WW-1:2*NW];

  // Usable nodes run from 1 to min(node_count, MAX_NODES).
  assign lim       = (ncnt_r < NW'(MAX_NODES)) ? ncnt_r : NW'(MAX_NODES);
  assign bad_edge  = (in_a == '0) || (in_b == '0) || (in_a > lim) || (in_b > lim);
  assign bad_start = (strt_r == '0) || (strt_r > lim);
  assign full      = ({1'b0, total_r} + (LW+1)'(2)) > (LW+1)'(EDGE_SLOTS);

  // A head entry that was never written since the last clear reads as empty.
  assign heff  = hv_r[hrd_addr_r] ? h_rdata : '0;
  assign lm1   = heff - LW'(1);
  assign e_wt  = e_rdata[WW-1:0];
  assign e_to  = e_rdata[WW+NW-1:WW];
  assign e_nl  = e_rdata[EE_W-1:WW+NW];
  assign d_inc = d_r + NW'(1);

  assign out_free  = !out_vld_r || out_tready;
  assign can_take  = (state_r == S_IDLE) && in_tvalid;
  assign in_tready = (state_r == S_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer. Each adjacency entry is examined in S_CHK, which waits while the output register is full; the
  // edge RAM read for the following entry is issued in the same cycle, except when depth-first descends.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    hv_nxt       = hv_r;
    vis_nxt      = vis_r;
    total_nxt    = total_r;
    hrd_addr_nxt = hrd_addr_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    w_nxt        = w_r;
    dfs_nxt      = dfs_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    top_nxt      = top_r;
    x_nxt        = x_r;
    d_nxt        = d_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_re = 1'b0; h_raddr = '0;
    e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_re = 1'b0; e_raddr = '0;
    wl_we = 1'b0; wl_waddr = '0; wl_wdata = '0; wl_re = 1'b0; wl_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (can_take) begin
          a_nxt = in_a;
          b_nxt = in_b;
          w_nxt = in_w;
          unique case (in_mode)
            alw_pkg::MODE_CLEAR: begin
              hv_nxt       = '0;
              total_nxt    = '0;
              pend_vld_nxt = 1'b1;
              pend_nxt     = alw_pkg::mk_res(alw_pkg::ST_CLEAR, '0, '0, '0, '0);
              state_nxt    = S_FIN;
            end
            alw_pkg::MODE_ADD: begin
              if (bad_edge || full) begin
                pend_vld_nxt = 1'b1;
                pend_nxt     = alw_pkg::mk_res(bad_edge ? alw_pkg::ST_BAD
                                                        : alw_pkg::ST_FULL,
                                               '0, '0, '0, '0);
                state_nxt    = S_FIN;
              end else begin
                h_re         = 1'b1;
                h_raddr      = in_a;
                hrd_addr_nxt = in_a;
                state_nxt    = S_ADD_WA;
              end
            end
            alw_pkg::MODE_BFS, alw_pkg::MODE_DFS: begin
              dfs_nxt      = (in_mode == alw_pkg::MODE_DFS);
              vis_nxt      = '0;
              pend_vld_nxt = 1'b1;
              if (bad_start) begin
                pend_nxt  = alw_pkg::mk_res(alw_pkg::ST_BAD, '0, '0, '0, '0);
                state_nxt = S_FIN;
              end else begin
                vis_nxt[strt_r] = 1'b1;
                pend_nxt  = alw_pkg::mk_res(alw_pkg::ST_VISIT, strt_r, '0, '0, '0);
                wl_we     = 1'b1;
                wl_waddr  = '0;
                wl_wdata  = {NW'(0), strt_r};
                head_nxt  = '0;
                tail_nxt  = NW'(1);
                top_nxt   = NW'(1);
                state_nxt = S_POP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Push the a->b entry onto the front of list a.
      S_ADD_WA: begin
        e_we       = 1'b1;
        e_waddr    = total_r[EW-1:0];
        e_wdata    = {heff, b_r, w_r};
        h_we       = 1'b1;
        h_waddr    = a_r;
        h_wdata    = total_r + LW'(1);
        hv_nxt[a_r] = 1'b1;
        total_nxt  = total_r + LW'(1);
        state_nxt  = S_ADD_RB;
      end

      // List b is read only now so that a self loop sees the first entry.
      S_ADD_RB: begin
        h_re         = 1'b1;
        h_raddr      = b_r;
        hrd_addr_nxt = b_r;
        state_nxt    = S_ADD_WB;
      end

      S_ADD_WB: begin
        e_we        = 1'b1;
        e_waddr     = total_r[EW-1:0];
        e_wdata     = {heff, a_r, w_r};
        h_we        = 1'b1;
        h_waddr     = b_r;
        h_wdata     = total_r + LW'(1);
        hv_nxt[b_r] = 1'b1;
        total_nxt   = total_r + LW'(1);
        pend_vld_nxt = 1'b1;
        pend_nxt    = alw_pkg::mk_res(alw_pkg::ST_STORED, '0, '0, '0, '0);
        state_nxt   = S_FIN;
      end

      // Breadth-first takes the oldest work entry, depth-first the top one.
      S_POP: begin
        if (dfs_r) begin
          if (top_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            wl_re     = 1'b1;
            wl_raddr  = top_r - NW'(1);
            state_nxt = S_NODE;
          end
        end else begin
          if (head_r == tail_r) begin
            state_nxt = S_FIN;
          end else begin
            wl_re     = 1'b1;
            wl_raddr  = head_r;
            head_nxt  = head_r + NW'(1);
            state_nxt = S_NODE;
          end
        end
      end

      S_NODE: begin
        x_nxt        = wl_rdata[NW-1:0];
        d_nxt        = wl_rdata[WL_W-1:NW];
        h_re         = 1'b1;
        h_raddr      = wl_rdata[NW-1:0];
        hrd_addr_nxt = wl_rdata[NW-1:0];
        state_nxt    = S_LINK;
      end

      S_LINK: begin
        if (heff == '0) begin
          if (dfs_r) begin
            top_nxt = top_r - NW'(1);
          end
          state_nxt = S_POP;
        end else begin
          e_re      = 1'b1;
          e_raddr   = lm1[EW-1:0];
          state_nxt = S_CHK;
        end
      end

      // Examine one adjacency entry. A newly reached node replaces the
      // pending result, which then moves to the output register.
      S_CHK: begin
        if (!vis_r[e_to]) begin
          if (out_free) begin
            out_vld_nxt   = 1'b1;
            out_nxt       = pend_r;
            out_last_nxt  = 1'b0;
            pend_nxt      = alw_pkg::mk_res(alw_pkg::ST_VISIT, e_to, d_inc, x_r, e_wt);
            vis_nxt[e_to] = 1'b1;
            wl_we         = 1'b1;
            wl_waddr      = dfs_r ? top_r : tail_r;
            wl_wdata      = {d_inc, e_to};
            if (dfs_r) begin
              top_nxt   = top_r + NW'(1);
              state_nxt = S_POP;
            end else begin
              tail_nxt = tail_r + NW'(1);
              if (e_nl != '0) begin
                e_re    = 1'b1;
                e_raddr = EW'(e_nl - LW'(1));
              end else begin
                state_nxt = S_POP;
              end
            end
          end
        end else if (e_nl != '0) begin
          e_re    = 1'b1;
          e_raddr = EW'(e_nl - LW'(1));
        end else begin
          if (dfs_r) begin
            top_nxt = top_r - NW'(1);
          end
          state_nxt = S_POP;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      hv_r       <= '0;
      vis_r      <= '0;
      total_r    <= '0;
      dfs_r      <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      top_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hv_r       <= hv_nxt;
      vis_r      <= vis_nxt;
      total_r    <= total_nxt;
      dfs_r      <= dfs_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      top_r      <= top_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hrd_addr_r <= hrd_addr_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    w_r        <= w_nxt;
    x_r        <= x_nxt;
    d_r        <= d_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // Memories: list heads, edge entries {link, to, weight}, and the work list
  // {depth, node} used as a FIFO or a stack.
  // --------------------------------------------------------------------------
  alw_ram #(.WIDTH(LW), .DEPTH(NS)) u_head_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  alw_ram #(.WIDTH(EE_W), .DEPTH(EDGE_SLOTS)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  alw_ram #(.WIDTH(WL_W), .DEPTH(NS)) u_work_ram (
    .clk(clk), .we(wl_we), .waddr(wl_waddr), .wdata(wl_wdata),
    .re(wl_re), .raddr(wl_raddr), .rdata(wl_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration port. Writes land in the access phase; pready is tied high.
  // --------------------------------------------------------------------------
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r <= NW'(63);
      strt_r <= NW'(1);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == alw_pkg::REG_NODE_COUNT) begin
        ncnt_r <= cfg_pwdata[NW-1:0];
      end else begin
        strt_r <= cfg_pwdata[NW-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == alw_pkg::REG_START_NODE) begin
      cfg_prdata = {26'd0, strt_r};
    end else begin
      cfg_prdata = {26'd0, ncnt_r};
    end
  end

  // Output beat. Non-visit results carry all-zero node fields by construction.
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_r.wt, out_r.parent, out_r.depth, out_r.node};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `ALW_ASSERT_NOW(a_idle_no_pend, state_r == S_IDLE, !pend_vld_r)
  `ALW_ASSERT_NOW(a_fin_has_pend, state_r == S_FIN, pend_vld_r)
  `ALW_ASSERT_NOW(a_single_last, out_vld_r && (out_r.status != alw_pkg::ST_VISIT), out_last_r)
  `ALW_ASSERT_NEXT(a_bfs_order, (state_r == S_CHK) && !dfs_r, head_r <= tail_r)

endmodule

`default_nettype wire
